### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the stored-stream PNG encoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/pse_pkg.sv
// Package of the stored-stream PNG encoder: types, byte codes and the CRC step.
// No dependencies; used by every other RTL file but assert_macros.svh.
`default_nettype none
package pse_pkg;

	localparam int DIM_W = 13;
	localparam int RAW_W = 28;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

	localparam logic [DIM_W-1:0] DIM_RESET = 13'd240;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	localparam logic [7:0] SIG_0 = 8'h89;
	localparam logic [7:0] SIG_1 = 8'h50;
	localparam logic [7:0] SIG_2 = 8'h4E;
	localparam logic [7:0] SIG_3 = 8'h47;
	localparam logic [7:0] SIG_4 = 8'h0D;
	localparam logic [7:0] SIG_5 = 8'h0A;
	localparam logic [7:0] SIG_6 = 8'h1A;
	localparam logic [7:0] SIG_7 = 8'h0A;
	localparam logic [7:0] IHDR_LEN = 8'd13;
	localparam logic [7:0] BIT_DEPTH = 8'd8;
	localparam logic [7:0] COLOR_RGB = 8'd2;
	localparam logic [7:0] ZLIB_CMF = 8'h78;
	localparam logic [7:0] ZLIB_FLG = 8'h01;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_T = 8'h54;

	// One accepted pixel with its position flags and the frame geometry.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic first;
		logic row_start;
		logic last;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} entry_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/pse_if.sv
// Channel interfaces of the stored-stream PNG encoder: pixels, bytes, config.
// Depends on pse_pkg for field widths.
`default_nettype none
interface pse_pix_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

interface pse_byte_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic file_end;
	modport source(output valid, out_byte, file_end, input ready);
	modport sink(input valid, out_byte, file_end, output ready);
endinterface

interface pse_cfg_if;
	logic valid;
	logic ready;
	logic [pse_pkg::CFG_IDX_W-1:0] index;
	logic [pse_pkg::DIM_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/pse_front.sv
// Front end: accepts pixels, tracks row and column, tags frame boundaries.
// Depends on pse_pkg and pse_if; also holds the geometry registers.
`default_nettype none
module pse_front #(
	parameter int MAX_DIM = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	pse_pix_if.sink pixel,
	pse_cfg_if.sink cfg,
	output pse_pkg::entry_t push_entry,
	output logic push,
	input wire logic full
);
	import pse_pkg::*;

	logic [DIM_W-1:0] width_q, height_q, col_q, row_q;
	logic frame_q;
	logic last_col, last_row;

	function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lo);
		logic [DIM_W-1:0] r;
		r = (v < lo) ? lo : v;
		if ({19'd0, r} > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

	assign pixel.ready = !full;
	assign push = pixel.valid && !full;
	assign cfg.ready = 1'b1;

	assign last_col = (col_q == width_q - 1'b1);
	assign last_row = (row_q == height_q - 1'b1);

	always_comb begin
		push_entry.red = pixel.red;
		push_entry.green = pixel.green;
		push_entry.blue = pixel.blue;
		push_entry.first = !frame_q;
		push_entry.row_start = (col_q == '0);
		push_entry.last = last_col && last_row;
		push_entry.width = width_q;
		push_entry.height = height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_RESET;
			height_q <= DIM_RESET;
			col_q <= '0;
			row_q <= '0;
			frame_q <= 1'b0;
		end else begin
			if (cfg.valid && !frame_q) begin
				if (cfg.index == CFG_IMAGE_WIDTH) begin
					width_q <= clamp(cfg.data, 13'd2);
				end else if (cfg.index == CFG_IMAGE_HEIGHT) begin
					height_q <= clamp(cfg.data, 13'd1);
				end
			end
			if (push) begin
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q <= '0;
						frame_q <= 1'b0;
					end else begin
						row_q <= row_q + 1'b1;
						frame_q <= 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
					frame_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### rtl/pse_fifo.sv
// Short pixel queue between the front and the back end.
// Depends on pse_pkg for the entry type.
`default_nettype none
module pse_fifo #(
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input pse_pkg::entry_t push_entry,
	output logic full,
	input wire logic pop,
	output logic valid,
	output pse_pkg::entry_t pop_entry
);
	import pse_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign valid = (cnt_q != '0);
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

### rtl/pse_blkdiv.sv
// Block counter for the IDAT length: ceil(raw / BLK_MAX) by a reciprocal multiply.
// Depends on pse_pkg for the raw byte count width.
`default_nettype none
module pse_blkdiv #(
	parameter int BLK_MAX = 65535
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [pse_pkg::RAW_W-1:0] raw,
	output logic done,
	output logic [pse_pkg::RAW_W-1:0] blocks
);
	import pse_pkg::*;

	// floor(x * RECIP / 2^SH) equals floor(x / BLK_MAX) for every x below 2^RAW_W,
	// since RECIP * BLK_MAX exceeds 2^SH by less than 2^(SH - RAW_W).
	localparam int SH = RAW_W + 16;
	localparam int MW = SH + 1;
	localparam int AW = RAW_W + SH;
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << SH) + 64'(BLK_MAX) - 64'd1) / 64'(BLK_MAX);
	localparam logic [MW-1:0] RECIP = RECIP_WIDE[MW-1:0];

	logic [RAW_W-1:0] x_q;
	logic [AW-1:0] acc_q;
	logic [1:0] step_q;
	logic busy_q, have_q;
	logic [15:0] chunk;
	logic [RAW_W+15:0] part;
	logic [5:0] shamt;

	// The reciprocal is applied 16 bits per cycle, low slice first.
	always_comb begin
		unique case (step_q)
			2'd0: chunk = RECIP[15:0];
			2'd1: chunk = RECIP[31:16];
			default: chunk = 16'(RECIP[MW-1:32]);
		endcase
	end

	assign part = {16'd0, x_q} * {{RAW_W{1'b0}}, chunk};
	assign shamt = {step_q, 4'd0};
	assign done = have_q && !busy_q;
	assign blocks = acc_q[AW-1:SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			have_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			have_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			busy_q <= (step_q != 2'd2);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= raw + RAW_W'(BLK_MAX - 1);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (AW'(part) << shamt);
		end
	end
endmodule
`default_nettype wire

### rtl/pse_back.sv
// Back end: byte sequencer that writes the PNG stream, with CRC and Adler.
// Depends on pse_pkg, pse_if and pse_blkdiv.
`default_nettype none
module pse_back #(
	parameter int BLK_MAX = 65535
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input pse_pkg::entry_t q_entry,
	output logic q_pop,
	pse_byte_if.source stream
);
	import pse_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_HEAD, S_RAW, S_TAIL} state_t;

	localparam logic [RAW_W-1:0] BLK_RAW = RAW_W'(BLK_MAX);

	state_t state_q;
	entry_t cur_q;
	logic [5:0] idx_q;
	logic [1:0] ridx_q;
	logic [2:0] hidx_q;
	logic [15:0] blk_left_q;
	logic [RAW_W-1:0] raw_left_q;
	logic [15:0] adl_lo_q, adl_hi_q;
	logic [31:0] crc_q;
	logic mul_go_s1, div_go_s2;
	logic ob_valid_q, ob_end_q;
	logic [7:0] ob_byte_q;

	logic div_done;
	logic [RAW_W-1:0] blocks;
	logic [RAW_W-1:0] product;
	logic [31:0] idat_len, crc_out, adler;
	logic [15:0] blk_n, blk_nn;
	logic blk_final, hdr_mode, stall, emit, raw_byte, item_done;
	logic [7:0] byte_c;
	logic feed_c, rst_c, end_c;
	logic [16:0] lo_sum, hi_sum;
	logic [15:0] lo_next, hi_next;

	pse_blkdiv #(.BLK_MAX(BLK_MAX)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_go_s2),
		.raw(raw_left_q),
		.done(div_done),
		.blocks(blocks)
	);

	assign product = RAW_W'(cur_q.height) *
		RAW_W'({2'b0, cur_q.width} + {1'b0, cur_q.width, 1'b0} + 15'd1);
	assign idat_len = 32'd6 + 32'(raw_left_q) + 32'(blocks) + (32'(blocks) << 2);
	assign crc_out = ~crc_q;
	assign adler = {adl_hi_q, adl_lo_q};

	assign blk_final = (raw_left_q <= BLK_RAW);
	assign blk_n = (raw_left_q < BLK_RAW) ? raw_left_q[15:0] : 16'(BLK_MAX);
	assign blk_nn = ~blk_n;
	assign hdr_mode = (blk_left_q == '0);

	assign stall = (state_q == S_HEAD) && (idx_q == 6'd33) && !div_done;
	assign emit = (state_q != S_IDLE) && !stall && (!ob_valid_q || stream.ready);
	assign raw_byte = emit && (state_q == S_RAW) && !hdr_mode;
	assign item_done = raw_byte && (ridx_q == 2'd3) && !cur_q.last;
	assign q_pop = q_valid && ((state_q == S_IDLE) || item_done);

	// Running Adler-32: each sum stays below twice the modulus.
	assign lo_sum = {1'b0, adl_lo_q} + {9'd0, byte_c};
	assign lo_next = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
	assign hi_sum = {1'b0, adl_hi_q} + {1'b0, lo_next};
	assign hi_next = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

	always_comb begin
		byte_c = 8'd0;
		feed_c = 1'b0;
		rst_c = 1'b0;
		end_c = 1'b0;
		unique case (state_q)
			S_HEAD: begin
				case (idx_q)
					6'd0: byte_c = SIG_0;
					6'd1: byte_c = SIG_1;
					6'd2: byte_c = SIG_2;
					6'd3: byte_c = SIG_3;
					6'd4: byte_c = SIG_4;
					6'd5: byte_c = SIG_5;
					6'd6: byte_c = SIG_6;
					6'd7: byte_c = SIG_7;
					6'd8, 6'd9, 6'd10: rst_c = 1'b1;
					6'd11: begin byte_c = IHDR_LEN; rst_c = 1'b1; end
					6'd12: begin byte_c = CH_I; feed_c = 1'b1; end
					6'd13: begin byte_c = CH_H; feed_c = 1'b1; end
					6'd14: begin byte_c = CH_D; feed_c = 1'b1; end
					6'd15: begin byte_c = CH_R; feed_c = 1'b1; end
					6'd16, 6'd17, 6'd20, 6'd21: feed_c = 1'b1;
					6'd18: begin byte_c = {3'd0, cur_q.width[12:8]}; feed_c = 1'b1; end
					6'd19: begin byte_c = cur_q.width[7:0]; feed_c = 1'b1; end
					6'd22: begin byte_c = {3'd0, cur_q.height[12:8]}; feed_c = 1'b1; end
					6'd23: begin byte_c = cur_q.height[7:0]; feed_c = 1'b1; end
					6'd24: begin byte_c = BIT_DEPTH; feed_c = 1'b1; end
					6'd25: begin byte_c = COLOR_RGB; feed_c = 1'b1; end
					6'd26, 6'd27, 6'd28: feed_c = 1'b1;
					6'd29: byte_c = crc_out[31:24];
					6'd30: byte_c = crc_out[23:16];
					6'd31: byte_c = crc_out[15:8];
					6'd32: byte_c = crc_out[7:0];
					6'd33: begin byte_c = idat_len[31:24]; rst_c = 1'b1; end
					6'd34: begin byte_c = idat_len[23:16]; rst_c = 1'b1; end
					6'd35: begin byte_c = idat_len[15:8]; rst_c = 1'b1; end
					6'd36: begin byte_c = idat_len[7:0]; rst_c = 1'b1; end
					6'd37: begin byte_c = CH_I; feed_c = 1'b1; end
					6'd38: begin byte_c = CH_D; feed_c = 1'b1; end
					6'd39: begin byte_c = CH_A; feed_c = 1'b1; end
					6'd40: begin byte_c = CH_T; feed_c = 1'b1; end
					6'd41: begin byte_c = ZLIB_CMF; feed_c = 1'b1; end
					6'd42: begin byte_c = ZLIB_FLG; feed_c = 1'b1; end
					default: byte_c = 8'd0;
				endcase
			end
			S_RAW: begin
				feed_c = 1'b1;
				if (hdr_mode) begin
					case (hidx_q)
						3'd0: byte_c = {7'd0, blk_final};
						3'd1: byte_c = blk_n[7:0];
						3'd2: byte_c = blk_n[15:8];
						3'd3: byte_c = blk_nn[7:0];
						default: byte_c = blk_nn[15:8];
					endcase
				end else begin
					unique case (ridx_q)
						2'd0: byte_c = 8'd0;
						2'd1: byte_c = cur_q.red;
						2'd2: byte_c = cur_q.green;
						2'd3: byte_c = cur_q.blue;
					endcase
				end
			end
			S_TAIL: begin
				case (idx_q)
					6'd0: begin byte_c = adler[31:24]; feed_c = 1'b1; end
					6'd1: begin byte_c = adler[23:16]; feed_c = 1'b1; end
					6'd2: begin byte_c = adler[15:8]; feed_c = 1'b1; end
					6'd3: begin byte_c = adler[7:0]; feed_c = 1'b1; end
					6'd4, 6'd16: byte_c = crc_out[31:24];
					6'd5, 6'd17: byte_c = crc_out[23:16];
					6'd6, 6'd18: byte_c = crc_out[15:8];
					6'd7: byte_c = crc_out[7:0];
					6'd8, 6'd9, 6'd10, 6'd11: rst_c = 1'b1;
					6'd12: begin byte_c = CH_I; feed_c = 1'b1; end
					6'd13: begin byte_c = CH_E; feed_c = 1'b1; end
					6'd14: begin byte_c = CH_N; feed_c = 1'b1; end
					6'd15: begin byte_c = CH_D; feed_c = 1'b1; end
					6'd19: begin byte_c = crc_out[7:0]; end_c = 1'b1; end
					default: byte_c = 8'd0;
				endcase
			end
			S_IDLE: byte_c = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			ridx_q <= '0;
			hidx_q <= '0;
			blk_left_q <= '0;
			raw_left_q <= '0;
			adl_lo_q <= 16'd1;
			adl_hi_q <= '0;
			crc_q <= CRC_INIT;
			mul_go_s1 <= 1'b0;
			div_go_s2 <= 1'b0;
			ob_valid_q <= 1'b0;
			ob_byte_q <= '0;
			ob_end_q <= 1'b0;
		end else begin
			mul_go_s1 <= q_pop && q_entry.first;
			div_go_s2 <= mul_go_s1;
			if (mul_go_s1) begin
				raw_left_q <= product;
			end

			if (emit) begin
				ob_valid_q <= 1'b1;
				ob_byte_q <= byte_c;
				ob_end_q <= end_c;
				if (rst_c) begin
					crc_q <= CRC_INIT;
				end else if (feed_c) begin
					crc_q <= crc_byte(crc_q, byte_c);
				end
			end else if (stream.ready) begin
				ob_valid_q <= 1'b0;
			end

			if (emit) begin
				unique case (state_q)
					S_HEAD: begin
						if (idx_q == 6'd42) begin
							state_q <= S_RAW;
							ridx_q <= 2'd0;
							hidx_q <= '0;
							blk_left_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					S_RAW: begin
						if (hdr_mode) begin
							if (hidx_q == 3'd4) begin
								hidx_q <= '0;
								blk_left_q <= blk_n;
							end else begin
								hidx_q <= hidx_q + 1'b1;
							end
						end else begin
							adl_lo_q <= lo_next;
							adl_hi_q <= hi_next;
							blk_left_q <= blk_left_q - 1'b1;
							if (raw_left_q != '0) begin
								raw_left_q <= raw_left_q - 1'b1;
							end
							if (ridx_q == 2'd3) begin
								if (cur_q.last) begin
									state_q <= S_TAIL;
									idx_q <= '0;
								end else if (!q_valid) begin
									state_q <= S_IDLE;
								end
							end else begin
								ridx_q <= ridx_q + 1'b1;
							end
						end
					end
					S_TAIL: begin
						if (idx_q == 6'd19) begin
							state_q <= S_IDLE;
							blk_left_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					S_IDLE: idx_q <= idx_q;
				endcase
			end

			// Taking the next pixel overrides the end-of-item step above.
			if (q_pop) begin
				if (q_entry.first) begin
					state_q <= S_HEAD;
					idx_q <= '0;
					adl_lo_q <= 16'd1;
					adl_hi_q <= '0;
				end else begin
					state_q <= S_RAW;
					ridx_q <= q_entry.row_start ? 2'd0 : 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
	end

	assign stream.valid = ob_valid_q;
	assign stream.out_byte = ob_byte_q;
	assign stream.file_end = ob_end_q;
endmodule
`default_nettype wire

### rtl/png_stored_stream_encoder.sv
// Top level of the stored-stream PNG encoder: front end, queue and back end.
// Depends on pse_pkg, pse_if, pse_front, pse_fifo, pse_back, assert_macros.svh.
//
// Usage. Pixels enter on the pixel channel, one RGB word per handshake, in
// raster order. The stream channel delivers the PNG file one byte word at a
// time; file_end marks the last byte of each file. The cfg channel writes
// image_width (index 0) and image_height (index 1); it is always ready, and
// a write is ignored while a frame is in progress. Out-of-range values are
// clamped to 2..MAX_DIM for width and 1..MAX_DIM for height.
// Each pixel yields three bytes, four for the first pixel of a row, all sent
// through the byte-wide output register. Each stored block adds five header
// bytes. The first pixel of a frame adds 43 header bytes, and the block count
// (a reciprocal multiply) runs under them; the header waits for it before the
// IDAT length. The last pixel is followed by 20 trailer bytes. An accepted
// pixel passes the queue and the entry register on to the output register.
// When the receiver stalls, the output register holds its word, the back end
// stops, the four-entry queue fills and then the pixel channel drops ready.
// Reset clears all control state; geometry returns to 240 by 240.
`default_nettype none
`include "assert_macros.svh"
module png_stored_stream_encoder #(
	parameter int MAX_DIM = 4096,
	parameter int STORED_BLOCK_MAX = 65535
) (
	input wire logic clk,
	input wire logic arst_n,
	pse_pix_if.sink pixel,
	pse_cfg_if.sink cfg,
	pse_byte_if.source stream
);
	import pse_pkg::*;

	entry_t push_entry, pop_entry;
	logic q_push, q_full, q_pop, q_valid;

	// The front end classifies each pixel: frame start, row start, frame end.
	pse_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.cfg(cfg),
		.push_entry(push_entry),
		.push(q_push),
		.full(q_full)
	);

	// The queue lets the front keep accepting while the back waits on output.
	pse_fifo #(.DEPTH(4)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(push_entry),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.pop_entry(pop_entry)
	);

	// The back end turns each entry into file bytes, with headers and checksums.
	pse_back #(.BLK_MAX(STORED_BLOCK_MAX)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_entry(pop_entry),
		.q_pop(q_pop),
		.stream(stream)
	);

	// The queue is never written when full nor read when empty.
	`PSE_ASSERT_IMPLY(a_no_overflow, clk, arst_n, q_push, !q_full)
	`PSE_ASSERT_IMPLY(a_no_underflow, clk, arst_n, q_pop, q_valid)
	// A pixel accepted into an empty queue is visible to the back end next cycle.
	`PSE_ASSERT_NEXT(a_push_seen, clk, arst_n, q_push && !q_valid, q_valid)
endmodule
`default_nettype wire

### dv/png_stored_stream_encoder_tb.sv
// Testbench of png_stored_stream_encoder: drives pixels and register writes
// and checks every PNG byte against a self-contained file predictor.
// Depends on pse_pkg, pse_if and the encoder RTL.
`default_nettype none
module png_stored_stream_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pse_pkg::*;

	localparam int MAX_DIM = 4096;
	localparam int STORED_BLOCK_MAX = 65535;
	localparam int STEP_CAP = 52;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd5;

	// Predicts the PNG byte stream that each accepted pixel produces and
	// holds the bytes that are still owed by the encoder.
	class png_byte_scoreboard;
		int unsigned width_used = 240;
		int unsigned height_used = 240;
		int unsigned adler_lo = 1;
		int unsigned adler_hi = 0;
		bit [31:0] crc = 32'hFFFFFFFF;
		int unsigned col = 0;
		int unsigned row = 0;
		int unsigned block_left = 0;
		int unsigned raw_left = 0;
		bit in_frame = 0;
		int step_count;
		bit [7:0] byte_q[$];
		bit end_q[$];
		int errors = 0;

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
			int unsigned v;
			v = 32'(value);
			if (in_frame)
				return;
			if (idx == CFG_IMAGE_WIDTH) begin
				width_used = (v < 2) ? 2 : (v > MAX_DIM) ? MAX_DIM : v;
			end else if (idx == CFG_IMAGE_HEIGHT) begin
				height_used = (v < 1) ? 1 : (v > MAX_DIM) ? MAX_DIM : v;
			end
		endfunction

		function void emit(bit [7:0] b, bit in_crc);
			bit [31:0] c;
			if (in_crc) begin
				c = crc ^ {24'd0, b};
				for (int k = 0; k < 8; k++)
					c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
				crc = c;
			end
			// A step can never owe more than the cap; excess bytes are dropped.
			if (step_count < STEP_CAP) begin
				byte_q.insert(byte_q.size(), b);
				end_q.insert(end_q.size(), 1'b0);
			end
			step_count++;
		endfunction

		function void emit_word(bit [31:0] w, bit in_crc);
			for (int i = 3; i >= 0; i--)
				emit(w[i*8 +: 8], in_crc);
		endfunction

		function void open_chunk(bit [31:0] len, bit [31:0] tag);
			emit_word(len, 0);
			crc = 32'hFFFFFFFF;
			emit_word(tag, 1);
		endfunction

		function void close_chunk();
			emit_word(crc ^ 32'hFFFFFFFF, 0);
			crc = 32'hFFFFFFFF;
		endfunction

		// Scanline byte: opens a stored block with its header when the last
		// one is used up, then feeds the running Adler-32.
		function void emit_raw(bit [7:0] b);
			int unsigned n;
			if (block_left == 0) begin
				n = (raw_left < STORED_BLOCK_MAX) ? raw_left : STORED_BLOCK_MAX;
				emit((raw_left <= STORED_BLOCK_MAX) ? 8'd1 : 8'd0, 1);
				emit(n[7:0], 1);
				emit(n[15:8], 1);
				emit(~n[7:0], 1);
				emit(~n[15:8], 1);
				block_left = n;
			end
			emit(b, 1);
			adler_lo = (adler_lo + b) % 65521;
			adler_hi = (adler_hi + adler_lo) % 65521;
			if (block_left > 0)
				block_left--;
			if (raw_left > 0)
				raw_left--;
		endfunction

		function void start_file();
			longint unsigned raw_total, blocks, idat_len;
			raw_total = longint'(height_used) * (1 + 3 * longint'(width_used));
			blocks = (raw_total + STORED_BLOCK_MAX - 1) / STORED_BLOCK_MAX;
			idat_len = 2 + raw_total + 5 * blocks + 4;
			emit(SIG_0, 0); emit(SIG_1, 0); emit(SIG_2, 0); emit(SIG_3, 0);
			emit(SIG_4, 0); emit(SIG_5, 0); emit(SIG_6, 0); emit(SIG_7, 0);
			open_chunk(32'd13, {CH_I, CH_H, CH_D, CH_R});
			emit_word(width_used, 1);
			emit_word(height_used, 1);
			emit(BIT_DEPTH, 1);
			emit(COLOR_RGB, 1);
			emit(8'd0, 1);
			emit(8'd0, 1);
			emit(8'd0, 1);
			close_chunk();
			open_chunk(idat_len[31:0], {CH_I, CH_D, CH_A, CH_T});
			emit(ZLIB_CMF, 1);
			emit(ZLIB_FLG, 1);
			adler_lo = 1;
			adler_hi = 0;
			col = 0;
			row = 0;
			block_left = 0;
			raw_left = raw_total[31:0];
			in_frame = 1;
		endfunction

		function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
			step_count = 0;
			if (!in_frame)
				start_file();
			if (col == 0)
				emit_raw(8'd0);
			emit_raw(r);
			emit_raw(g);
			emit_raw(b);
			col++;
			if (col >= width_used) begin
				col = 0;
				row++;
				if (row >= height_used) begin
					emit_word({adler_hi[15:0], adler_lo[15:0]}, 1);
					close_chunk();
					open_chunk(32'd0, {CH_I, CH_E, CH_N, CH_D});
					close_chunk();
					in_frame = 0;
					col = 0;
					row = 0;
					block_left = 0;
					raw_left = 0;
					end_q[end_q.size() - 1] = 1'b1;
				end
			end
		endfunction

		function void check_byte(bit [7:0] b, bit e);
			bit [7:0] want_b;
			bit want_e;
			if (byte_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected byte word %02h end %0b", b, e);
				return;
			end
			want_b = byte_q.pop_front();
			want_e = end_q.pop_front();
			if (want_b !== b || want_e !== e) begin
				errors++;
				if (errors <= 10)
					$display("byte mismatch: expected %02h end %0b, got %02h end %0b",
						want_b, want_e, b, e);
			end
		endfunction

		function int owed();
			return byte_q.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;

	pse_pix_if pixel();
	pse_cfg_if cfg();
	pse_byte_if stream();

	png_stored_stream_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.cfg(cfg),
		.stream(stream)
	);

	png_byte_scoreboard sb = new();

	// Random idling on both channels while set; cleared for the final part.
	bit idle_on = 1;
	// Cycles the receiver must hold ready low, requested by the main sequence.
	int hold_request = 0;

	always #10 clk = ~clk;

	initial begin
		pixel.valid = 0;
		pixel.red = 0;
		pixel.green = 0;
		pixel.blue = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		stream.ready = 0;
	end

	// Receiver: checks each accepted byte word, then picks ready for the next
	// edge. A requested hold-off is counted here, in cycles, independent of
	// the sender, so the internal queue fills and pixel ready drops.
	initial begin
		int hold_left;
		int gap_left;
		hold_left = 0;
		gap_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stream.valid && stream.ready)
				sb.check_byte(stream.out_byte, stream.file_end);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				stream.ready <= 0;
			end else if (gap_left > 0) begin
				gap_left--;
				stream.ready <= 0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				gap_left = $urandom_range(1, 5) - 1;
				stream.ready <= 0;
			end else begin
				stream.ready <= 1;
			end
		end
	end

	// Offers one pixel word, maybe after a random gap, and waits until it is
	// taken. Called at a rising edge; returns at the edge of acceptance with
	// valid still high, so back-to-back words need no extra edge.
	task automatic send_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			pixel.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pixel.valid <= 1;
		pixel.red <= r;
		pixel.green <= g;
		pixel.blue <= b;
		@(posedge clk);
		while (!pixel.ready)
			@(posedge clk);
		sb.note_pixel(r, g, b);
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		pixel.valid <= 0;
	endtask

	// Register writes go through the scoreboard too, since it decides on its
	// own whether a write lands (it is dropped while a frame is open).
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		sb.set_register(idx, value);
		cfg.valid <= 0;
	endtask

	// Waits until every owed byte has arrived, plus a few cycles of margin.
	task automatic drain();
		while (sb.owed() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		send_random(int'(sb.width_used * sb.height_used));
		drain();
	endtask

	initial begin
		int sent;
		int w;
		int h;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Both registers below their floor: smallest legal image, 2 by 1,
		// with all-zero and all-one pixels.
		write_reg(CFG_IMAGE_WIDTH, 13'd0);
		write_reg(CFG_IMAGE_HEIGHT, 13'd0);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		pixel.valid <= 0;
		drain();

		// A 3 by 2 frame. In the middle of it the sender waits for every
		// owed byte, then writes a width (dropped, frame still open) and an
		// unknown register index (dropped always).
		write_reg(CFG_IMAGE_WIDTH, 13'd3);
		write_reg(CFG_IMAGE_HEIGHT, 13'd2);
		send_pixel(8'h55, 8'hAA, 8'h55);
		send_pixel(8'hAA, 8'h55, 8'hAA);
		pixel.valid <= 0;
		drain();
		write_reg(CFG_IMAGE_WIDTH, 13'd9);
		write_reg(CFG_UNUSED, 13'h1FFF);
		send_random(4);
		drain();

		// Back pressure: the receiver holds off for a long stretch while
		// the sender keeps offering pixels of a 6 by 3 frame.
		write_reg(CFG_IMAGE_WIDTH, 13'd6);
		write_reg(CFG_IMAGE_HEIGHT, 13'd3);
		hold_request = 300;
		send_random(18);
		drain();

		// Random small frames with random idling on both sides.
		sent = 0;
		while (sent < 120) begin
			w = $urandom_range(2, 7);
			h = $urandom_range(1, 3);
			run_frame(DIM_W'(w), DIM_W'(h));
			sent += w * h;
		end

		// Last part without idling: two small frames back to back.
		idle_on = 0;
		run_frame(13'd5, 13'd3);
		run_frame(13'd2, 13'd2);

		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.owed() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
